FILE: rtl/fixed_point_sqrt_shift_add_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-point square root block
// Clocked assertions with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_SQRT_SHIFT_ADD_ASSERT_SVH
`define FIXED_POINT_SQRT_SHIFT_ADD_ASSERT_SVH

// Checked only while out of reset
`define FPSQRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included
`define FPSQRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: rtl/fpsqrt_pkg.sv
// ----------------------------------------------------------------------------
// fpsqrt_pkg
// Widths and constants shared by the square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package fpsqrt_pkg;

  localparam int DATA_W         = 32;
  localparam int PRE_SHIFT      = 7;
  localparam int POST_SHIFT     = 8;
  localparam int ROOT_W         = DATA_W - POST_SHIFT;
  localparam int ITERATIONS_DEF = 13;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [ROOT_W-1:0] root_t;

endpackage

`default_nettype wire

FILE: rtl/fpsqrt_stage.sv
// ----------------------------------------------------------------------------
// fpsqrt_stage
// One normalisation step: v <- v(1+2^-k)^2 and g <- g(1+2^-k) unless a carry.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_stage #(
  parameter int SHIFT = 1
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               ready_o,
  input  fpsqrt_pkg::word_t  v_i,
  input  fpsqrt_pkg::word_t  g_i,
  output logic               valid_o,
  input  wire                ready_i,
  output fpsqrt_pkg::word_t  v_o,
  output fpsqrt_pkg::word_t  g_o
);
  import fpsqrt_pkg::*;

  logic              valid_q;
  word_t             v_q, g_q;
  word_t             v_d, g_d;
  logic [DATA_W:0]   t_sum, u_sum;
  logic              keep;

  always_comb begin
    t_sum = {1'b0, v_i} + {1'b0, v_i >> SHIFT};
    u_sum = {1'b0, t_sum[DATA_W-1:0]} + {1'b0, t_sum[DATA_W-1:0] >> SHIFT};
    keep  = !t_sum[DATA_W] && !u_sum[DATA_W];
    v_d   = keep ? u_sum[DATA_W-1:0] : v_i;
    g_d   = keep ? (g_i + (g_i >> SHIFT)) : g_i;
  end

  // Take a new transaction when empty or when the downstream drains this one
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      v_q <= v_d;
      g_q <= g_d;
    end
  end

  assign valid_o = valid_q;
  assign v_o     = v_q;
  assign g_o     = g_q;

endmodule

`default_nettype wire

FILE: rtl/fixed_point_sqrt_shift_add.sv
// ----------------------------------------------------------------------------
// fixed_point_sqrt_shift_add - Q9.23 square root, shift-add normalisation
// Registered stages: one per normalisation step, then the product, then the sum.
// Throughput: one transaction per cycle while out_ready_i is high; each stage holds one operand.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_sqrt_shift_add #(
  parameter int ITERATIONS = fpsqrt_pkg::ITERATIONS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  fpsqrt_pkg::word_t  operand_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output fpsqrt_pkg::root_t  root_o
);
  import fpsqrt_pkg::*;

  logic  stage_valid [ITERATIONS+1];
  logic  stage_ready [ITERATIONS+1];
  word_t stage_v     [ITERATIONS+1];
  word_t stage_g     [ITERATIONS+1];

  assign stage_valid[0] = in_valid_i;
  assign stage_v[0]     = operand_i << PRE_SHIFT;
  assign stage_g[0]     = operand_i << PRE_SHIFT;
  assign in_ready_o     = stage_ready[0];

  for (genvar i = 1; i <= ITERATIONS; i++) begin : g_step
    fpsqrt_stage #(
      .SHIFT (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stage_valid[i-1]),
      .ready_o (stage_ready[i-1]),
      .v_i     (stage_v[i-1]),
      .g_i     (stage_g[i-1]),
      .valid_o (stage_valid[i]),
      .ready_i (stage_ready[i]),
      .v_o     (stage_v[i]),
      .g_o     (stage_g[i])
    );
  end

  // Correction product: high word of (2^32 - v) * g
  logic                mul_valid_q;
  logic                mul_ready;
  word_t               mul_hi_q, mul_g_q;
  word_t               neg_v;
  logic [2*DATA_W-1:0] prod;

  // Final sum and shift
  logic                out_valid_q;
  logic                out_ready;
  root_t               root_q;
  word_t               sum;

  assign neg_v = '0 - stage_v[ITERATIONS];
  assign prod  = neg_v * stage_g[ITERATIONS];

  assign out_ready              = !out_valid_q || out_ready_i;
  assign mul_ready              = !mul_valid_q || out_ready;
  assign stage_ready[ITERATIONS] = mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_q <= stage_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && stage_valid[ITERATIONS]) begin
      mul_hi_q <= prod[2*DATA_W-1:DATA_W];
      mul_g_q  <= stage_g[ITERATIONS];
    end
  end

  assign sum = mul_g_q + (mul_hi_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && mul_valid_q) begin
      root_q <= sum[DATA_W-1:POST_SHIFT];
    end
  end

  assign out_valid_o = out_valid_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

FILE: rtl/fpsqrt_checker.sv
// ----------------------------------------------------------------------------
// fpsqrt_checker
// Port-level checks on the square root pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fpsqrt_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input fpsqrt_pkg::root_t  root_o
);
  `include "fixed_point_sqrt_shift_add_assert.svh"

  // A stalled result must hold
  `FPSQRT_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_o), "result changed while stalled")

  // Input back-pressure only when the result is blocked downstream
  `FPSQRT_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without output back-pressure")

  // An empty output stage never blocks the input
  `FPSQRT_ASSERT(a_empty_ready, !out_valid_o |-> in_ready_o, "input stalled with output empty")

  // No result during reset
  `FPSQRT_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result offered during reset")

endmodule

bind fixed_point_sqrt_shift_add fpsqrt_checker u_fpsqrt_checker (.*);

`default_nettype wire
